/* src/acm_pkg.sv */
// Shared constants, types and configuration layout of the audio channel mixer.
package acm_pkg;

  // Mixer size and internal scaling.
  localparam int NumChannels   = 4;
  localparam int MixCh         = (NumChannels < 4) ? NumChannels : 4;
  // The internal range must be a power of two.
  localparam int InternalRange = 1024;
  localparam int IrShift       = $clog2(InternalRange);
  localparam int FracBits      = 12;
  localparam int DivShift      = FracBits + IrShift;

  // Field and register widths.
  localparam int SampleW  = 16;
  localparam int GainW    = 16;
  localparam int FmtW     = 2;
  localparam int VolW     = 10;
  localparam int RangeW   = 16;
  localparam int MaskW    = 16;
  localparam int SilW     = 11;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  // Datapath widths.
  localparam int DecW     = SampleW + 1;
  localparam int ProdW    = DecW + GainW + 1;
  localparam int AccW     = ProdW + 2;
  localparam int VolProdW = AccW + VolW;
  localparam int ScaledW  = VolProdW + RangeW + 1;
  localparam int MagFullW = ScaledW - DivShift;

  // Division by the unity volume through a reciprocal multiply.
  localparam int    VolUnity   = 1023;
  localparam int    MagW       = 26;
  localparam int    RecipShift = 36;
  localparam int    RecipW     = 27;
  localparam longint Recip     = ((64'd1 << RecipShift) + VolUnity - 1) / VolUnity;
  localparam longint SatLimit  = longint'(VolUnity) * 65536;
  localparam int    QW         = 17;
  localparam int    SatQ       = 65536;
  localparam int    OutSW      = QW + 1;

  // Offset that centres unsigned channel formats, in Q.12 units.
  localparam logic signed [AccW-1:0] HalfIr  = AccW'(InternalRange / 2);
  localparam logic signed [AccW-1:0] HalfIrQ = HalfIr <<< FracBits;

  // Sample encodings.
  typedef enum logic [FmtW-1:0] {
    FmtU8  = 2'd0,
    FmtS8  = 2'd1,
    FmtU16 = 2'd2,
    FmtS16 = 2'd3
  } fmt_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgGains   = 3'd0,
    CfgFormats = 3'd1,
    CfgOutFmt  = 3'd2,
    CfgVolume  = 3'd3,
    CfgRange   = 3'd4,
    CfgMask    = 3'd5,
    CfgSilence = 3'd6
  } cfg_idx_e;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [4*GainW-1:0] gains;
    logic [4*FmtW-1:0]  formats;
    fmt_e               out_fmt;
    logic [VolW-1:0]    volume;
    logic [RangeW-1:0]  range;
    logic [MaskW-1:0]   mask;
    logic [SilW-1:0]    silence;
  } cfg_t;

  // Products of the lane multipliers.
  typedef struct packed {
    logic [MixCh-1:0][ProdW-1:0] prod;
    logic [MixCh-1:0]            centre;
    logic [MixCh-1:0]            present;
  } lane_t;

  // Quotient magnitude and sign before clamping.
  typedef struct packed {
    logic          neg;
    logic [QW-1:0] mag;
  } quot_t;

endpackage

/* src/acm_frame_if.sv */
// Input channel carrying one frame of raw channel samples.
interface acm_frame_if;
  import acm_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample_a;
  logic [SampleW-1:0] sample_b;
  logic [SampleW-1:0] sample_c;
  logic [SampleW-1:0] sample_d;
  logic               present_a;
  logic               present_b;
  logic               present_c;
  logic               present_d;

  modport source (
    output valid, sample_a, sample_b, sample_c, sample_d,
    output present_a, present_b, present_c, present_d,
    input  ready
  );
  modport sink (
    input  valid, sample_a, sample_b, sample_c, sample_d,
    input  present_a, present_b, present_c, present_d,
    output ready
  );
endinterface

/* src/acm_mix_if.sv */
// Output channel carrying one mixed sample.
interface acm_mix_if;
  import acm_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] mixed_sample;

  modport source (output valid, mixed_sample, input ready);
  modport sink (input valid, mixed_sample, output ready);
endinterface

/* src/acm_lane_mult.sv */
// First stage: per-channel sample decode and gain multiply.
module acm_lane_mult (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  acm_pkg::cfg_t cfg_i,
  acm_frame_if.sink     frame_i,
  output logic          valid_o,
  input  logic          ready_i,
  output acm_pkg::lane_t lane_o
);
  import acm_pkg::*;

  logic [3:0][SampleW-1:0] raw;
  logic [3:0]              pres;
  logic                    valid_q;
  logic                    ready;
  lane_t                   lane_d;
  lane_t                   lane_q;

  assign raw  = {frame_i.sample_d, frame_i.sample_c, frame_i.sample_b, frame_i.sample_a};
  assign pres = {frame_i.present_d, frame_i.present_c, frame_i.present_b, frame_i.present_a};

  // One decoder and one multiplier for each channel.
  for (genvar i = 0; i < MixCh; i++) begin : g_lane
    fmt_e                    fmt;
    logic signed [DecW-1:0]  dec;
    logic signed [ProdW-1:0] prod;

    assign fmt = fmt_e'(cfg_i.formats[FmtW*i +: FmtW]);

    always_comb begin
      case (fmt)
        FmtU8:   dec = {{(DecW-8){1'b0}}, raw[i][7:0]};
        FmtS8:   dec = {{(DecW-8){raw[i][7]}}, raw[i][7:0]};
        FmtU16:  dec = {1'b0, raw[i]};
        default: dec = {raw[i][SampleW-1], raw[i]};
      endcase
      prod = dec * $signed({1'b0, cfg_i.gains[GainW*i +: GainW]});
    end

    assign lane_d.prod[i]    = prod;
    assign lane_d.centre[i]  = ~fmt[0];
    assign lane_d.present[i] = pres[i];
  end

  // The stage takes a new item whenever it is empty or its item moves on.
  assign ready         = !valid_q || ready_i;
  assign frame_i.ready = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && frame_i.valid) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

/* src/acm_accum.sv */
// Second stage: sums the channel contributions or substitutes the silence level.
module acm_accum (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  acm_pkg::cfg_t                    cfg_i,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  acm_pkg::lane_t                   lane_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic signed [acm_pkg::AccW-1:0]  acc_o
);
  import acm_pkg::*;

  logic                   valid_q;
  logic signed [AccW-1:0] acc_d;
  logic signed [AccW-1:0] acc_q;
  logic signed [AccW-1:0] term;
  logic signed [AccW-1:0] sil;

  // Centred, gain-scaled contributions of the present channels.
  always_comb begin
    acc_d = '0;
    term  = '0;
    for (int i = 0; i < MixCh; i++) begin
      term = AccW'($signed(lane_i.prod[i]));
      if (lane_i.centre[i]) begin
        term = term - HalfIrQ;
      end
      if (lane_i.present[i]) begin
        acc_d = acc_d + term;
      end
    end
    sil = ($signed({{(AccW-SilW){1'b0}}, cfg_i.silence}) - HalfIr) <<< FracBits;
    if (lane_i.present == '0) begin
      acc_d = sil;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      acc_q <= acc_d;
    end
  end

  assign valid_o = valid_q;
  assign acc_o   = acc_q;

endmodule

/* src/acm_scale.sv */
// Stages three to five: master volume, output range and unsigned offset.
module acm_scale (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  acm_pkg::cfg_t                      cfg_i,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [acm_pkg::AccW-1:0]    acc_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic signed [acm_pkg::ScaledW-1:0] num_o
);
  import acm_pkg::*;

  logic                       vol_valid_q;
  logic                       rng_valid_q;
  logic                       off_valid_q;
  logic                       vol_ready;
  logic                       rng_ready;
  logic                       off_ready;
  logic signed [VolProdW:0]   vol_full;
  logic signed [VolProdW-1:0] vol_q;
  logic signed [ScaledW-1:0]  rng_d;
  logic signed [ScaledW-1:0]  rng_q;
  logic [RangeW-2:0]          off;
  logic [ScaledW-1:0]         off_scaled;
  logic signed [ScaledW-1:0]  num_d;
  logic signed [ScaledW-1:0]  num_q;

  // Accumulator times master volume.
  assign vol_full = acc_i * $signed({1'b0, cfg_i.volume});

  // Times the output range.
  assign rng_d = vol_q * $signed({1'b0, cfg_i.range});

  // Half the range, in units of the full divisor, centres unsigned output.
  always_comb begin
    off        = cfg_i.out_fmt[0] ? '0 : cfg_i.range[RangeW-1:1];
    off_scaled = (ScaledW'(off) * ScaledW'(VolUnity)) << DivShift;
    num_d      = rng_q + $signed(off_scaled);
  end

  assign off_ready = !off_valid_q || ready_i;
  assign rng_ready = !rng_valid_q || off_ready;
  assign vol_ready = !vol_valid_q || rng_ready;
  assign ready_o   = vol_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_valid_q <= 1'b0;
      rng_valid_q <= 1'b0;
      off_valid_q <= 1'b0;
    end else begin
      if (vol_ready) begin
        vol_valid_q <= valid_i;
      end
      if (rng_ready) begin
        rng_valid_q <= vol_valid_q;
      end
      if (off_ready) begin
        off_valid_q <= rng_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vol_ready && valid_i) begin
      vol_q <= vol_full[VolProdW-1:0];
    end
    if (rng_ready && vol_valid_q) begin
      rng_q <= rng_d;
    end
    if (off_ready && rng_valid_q) begin
      num_q <= num_d;
    end
  end

  assign valid_o = off_valid_q;
  assign num_o   = num_q;

endmodule

/* src/acm_recip_div.sv */
// Stages six and seven: truncating division by the full-scale divisor.
module acm_recip_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [acm_pkg::ScaledW-1:0] num_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output acm_pkg::quot_t                     quot_o
);
  import acm_pkg::*;

  logic                     mag_valid_q;
  logic                     quot_valid_q;
  logic                     mag_ready;
  logic                     quot_ready;
  logic [ScaledW-1:0]       mag;
  logic [MagFullW-1:0]      mag_full;
  logic                     sat_d;
  logic [MagW-1:0]          mag_d;
  logic [MagW-1:0]          mag_q;
  logic                     sat_q;
  logic                     neg_q;
  logic [MagW+RecipW-1:0]   prod;
  quot_t                    quot_d;
  quot_t                    quot_q;

  // Magnitude shifted by the power-of-two part of the divisor; large values saturate.
  always_comb begin
    mag      = num_i[ScaledW-1] ? ScaledW'(-num_i) : ScaledW'(num_i);
    mag_full = MagFullW'(mag >> DivShift);
    sat_d    = mag_full >= MagFullW'(SatLimit);
    mag_d    = sat_d ? '0 : mag_full[MagW-1:0];
  end

  // Division by the unity volume through the rounded-up reciprocal, exact in range.
  always_comb begin
    prod       = mag_q * RecipW'(Recip);
    quot_d.neg = neg_q;
    quot_d.mag = sat_q ? QW'(SatQ) : prod[RecipShift +: QW];
  end

  assign quot_ready = !quot_valid_q || ready_i;
  assign mag_ready  = !mag_valid_q || quot_ready;
  assign ready_o    = mag_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_valid_q  <= 1'b0;
      quot_valid_q <= 1'b0;
    end else begin
      if (mag_ready) begin
        mag_valid_q <= valid_i;
      end
      if (quot_ready) begin
        quot_valid_q <= mag_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mag_ready && valid_i) begin
      mag_q <= mag_d;
      sat_q <= sat_d;
      neg_q <= num_i[ScaledW-1];
    end
    if (quot_ready && mag_valid_q) begin
      quot_q <= quot_d;
    end
  end

  assign valid_o = quot_valid_q;
  assign quot_o  = quot_q;

endmodule

/* src/audio_channel_mixer.sv */
// A frame accepted from frame_i passes through the lane, accumulator, volume, range, offset,
// magnitude, quotient and output registers in that order before it appears on mix_o.
// Throughput: one frame per cycle unless a stall holds it; the eight register stages each hold
// one frame and stall from the output backwards when the result is not taken.
// Reset clears every stage's valid bit and returns the configuration registers to
// their defaults; the datapath registers are not reset.
module audio_channel_mixer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [acm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [acm_pkg::CfgDataW-1:0]   cfg_data_i,
  acm_frame_if.sink                      frame_i,
  acm_mix_if.source                      mix_o
);
  import acm_pkg::*;

  cfg_t                     cfg_q;
  logic                     lane_valid;
  logic                     acc_ready;
  lane_t                    lane;
  logic                     acc_valid;
  logic                     sca_ready;
  logic signed [AccW-1:0]   acc;
  logic                     sca_valid;
  logic                     div_ready;
  logic signed [ScaledW-1:0] num;
  logic                     div_valid;
  logic                     out_ready;
  quot_t                    quot;
  logic                     out_valid_q;
  logic [SampleW-1:0]       out_q;
  logic [SampleW-1:0]       out_d;
  logic signed [OutSW-1:0]  s;
  logic signed [OutSW-1:0]  lo;
  logic signed [OutSW-1:0]  hi;
  logic signed [OutSW-1:0]  half;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gains   <= 64'h1000_1000_1000_1000;
      cfg_q.formats <= 8'hFF;
      cfg_q.out_fmt <= FmtU16;
      cfg_q.volume  <= VolW'(VolUnity);
      cfg_q.range   <= RangeW'(1024);
      cfg_q.mask    <= '0;
      cfg_q.silence <= SilW'(InternalRange / 2);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgGains:   cfg_q.gains   <= cfg_data_i;
        CfgFormats: cfg_q.formats <= cfg_data_i[4*FmtW-1:0];
        CfgOutFmt:  cfg_q.out_fmt <= fmt_e'(cfg_data_i[FmtW-1:0]);
        CfgVolume:  cfg_q.volume  <= cfg_data_i[VolW-1:0];
        CfgRange:   cfg_q.range   <= cfg_data_i[RangeW-1:0];
        CfgMask:    cfg_q.mask    <= cfg_data_i[MaskW-1:0];
        CfgSilence: cfg_q.silence <= cfg_data_i[SilW-1:0];
        default:    ;
      endcase
    end
  end

  acm_lane_mult u_lane_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .frame_i (frame_i),
    .valid_o (lane_valid),
    .ready_i (acc_ready),
    .lane_o  (lane)
  );

  acm_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (lane_valid),
    .ready_o (acc_ready),
    .lane_i  (lane),
    .valid_o (acc_valid),
    .ready_i (sca_ready),
    .acc_o   (acc)
  );

  acm_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (acc_valid),
    .ready_o (sca_ready),
    .acc_i   (acc),
    .valid_o (sca_valid),
    .ready_i (div_ready),
    .num_o   (num)
  );

  acm_recip_div u_recip_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sca_valid),
    .ready_o (div_ready),
    .num_i   (num),
    .valid_o (div_valid),
    .ready_i (out_ready),
    .quot_o  (quot)
  );

  // Sign, clamp to the output range, OR in the mask and trim 8-bit formats.
  always_comb begin
    s     = quot.neg ? -$signed({1'b0, quot.mag}) : $signed({1'b0, quot.mag});
    half  = $signed({{(OutSW-RangeW+1){1'b0}}, cfg_q.range[RangeW-1:1]});
    lo    = cfg_q.out_fmt[0] ? -half : '0;
    hi    = cfg_q.out_fmt[0] ? half : $signed({{(OutSW-RangeW){1'b0}}, cfg_q.range});
    if (s < lo) begin
      s = lo;
    end
    if (s > hi) begin
      s = hi;
    end
    out_d = s[SampleW-1:0] | cfg_q.mask;
    if (cfg_q.out_fmt == FmtU8 || cfg_q.out_fmt == FmtS8) begin
      out_d[SampleW-1:8] = '0;
    end
  end

  // Output register.
  assign out_ready = !out_valid_q || mix_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && div_valid) begin
      out_q <= out_d;
    end
  end

  assign mix_o.valid        = out_valid_q;
  assign mix_o.mixed_sample = out_q;

`ifndef SYNTHESIS
  // An accepted frame always lands in the first stage.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_i.valid && frame_i.ready |=> lane_valid)
    else $error("accepted frame did not reach the lane stage");

  // An empty first stage never back-pressures the input.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lane_valid |-> frame_i.ready)
    else $error("input stalled with an empty lane stage");

  // A frame held in the first stage by a stall is not dropped.
  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_valid && !acc_ready |=> lane_valid)
    else $error("stalled frame lost in the lane stage");
`endif

endmodule
